@@ rtl/core/tfp_pkg.sv @@
// Shared types, constants and helpers of the time frame parser.
// No dependencies; imported by every module of the block but tfp_ram.
`default_nettype none

package tfp_pkg;

    localparam int MAX_ZONE    = 32;               // longest accepted zone name
    localparam int HDR_BYTES   = 9;
    localparam int COUNT_W     = 6;
    localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
    localparam int ZONE_DEPTH  = 2 * MAX_ZONE;     // two frame buffers
    localparam int ZADDR_W     = $clog2(ZONE_DEPTH);
    localparam int Q_DEPTH     = 2;
    localparam int QPTR_W      = $clog2(Q_DEPTH);
    localparam int QCNT_W      = $clog2(Q_DEPTH + 1);
    localparam int OUT_FIELD_W = 8 + 3 + 32 + 16 + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
    localparam int CFG_IDX_W   = 3;

    localparam logic [7:0]         RST_MAGIC   = 8'd0;
    localparam logic [7:0]         RST_VERSION = 8'd1;
    localparam logic [31:0]        RST_FLOOR   = 32'd0;
    localparam logic signed [15:0] RST_OFS_LO  = -16'sd720;
    localparam logic signed [15:0] RST_OFS_HI  = 16'sd840;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_ZONE_LONG = 3'd3,
        ST_LENGTH    = 3'd4,
        ST_EARLY     = 3'd5,
        ST_OFFSET    = 3'd6
    } t_status;

    typedef enum logic {
        KIND_ZONE    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC   = 3'd0,
        CFG_VERSION = 3'd1,
        CFG_FLOOR   = 3'd2,
        CFG_OFS_LO  = 3'd3,
        CFG_OFS_HI  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [7:0]         magic;
        logic [7:0]         version;
        logic [31:0]        floor;
        logic signed [15:0] ofs_lo;
        logic signed [15:0] ofs_hi;
    } t_cfg;

    // one finished frame, handed from the front end to the back end
    typedef struct packed {
        t_status              status;
        logic [31:0]          secs;
        logic [15:0]          offs;
        logic [COUNT_W-1:0]   zlen;
        logic                 bank;
    } t_desc;

    function automatic logic [ZADDR_W-1:0] zaddr(input logic bank,
                                                 input logic [COUNT_W-1:0] pos);
        logic [ZADDR_W-1:0] base;
        base = bank ? ZADDR_W'(MAX_ZONE) : '0;
        return base + ZADDR_W'(pos);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tfp_front.sv @@
// Front end: counts frame bytes, keeps the header, writes zone bytes to the
// zone buffer and judges the frame on its last byte. Depends on tfp_pkg.
`default_nettype none

module tfp_front
    import tfp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_last,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output t_desc                   o_desc,
    output logic                    o_zone_we,
    output logic [ZADDR_W-1:0]      o_zone_addr,
    output logic [7:0]              o_zone_wdata
);

    logic [COUNT_W-1:0] r_count;
    logic               r_bank;
    logic [7:0]         r_hdr [HDR_BYTES];

    logic [7:0]         hdr [HDR_BYTES];
    logic               accept;
    logic [COUNT_W-1:0] len;
    logic [COUNT_W-1:0] zpos;
    logic               zone_wr;
    logic [31:0]        secs;
    logic signed [15:0] offs;
    logic [8:0]         want_len;
    t_status            status;

    // a queue slot free means the write-side buffer half is free too
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // header as it stands once the current byte is in
    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr[i] = (r_count == COUNT_W'(i)) ? i_byte : r_hdr[i];
        end
    end

    assign len  = (r_count < COUNT_W'(COUNT_MAX)) ? r_count + COUNT_W'(1)
                                                  : COUNT_W'(COUNT_MAX);
    assign zpos = r_count - COUNT_W'(HDR_BYTES);
    assign zone_wr = (r_count >= COUNT_W'(HDR_BYTES)) &&
                     (r_count < COUNT_W'(COUNT_MAX)) &&
                     (zpos < COUNT_W'(MAX_ZONE));

    assign o_zone_we    = accept && zone_wr;
    assign o_zone_addr  = zaddr(r_bank, zpos);
    assign o_zone_wdata = i_byte;

    assign secs     = {hdr[5], hdr[4], hdr[3], hdr[2]};
    assign offs     = $signed({hdr[7], hdr[6]});
    assign want_len = 9'(hdr[8]) + 9'(HDR_BYTES);

    always_comb begin
        if (len < COUNT_W'(HDR_BYTES)) begin
            status = ST_SHORT;
        end else if (hdr[0] != i_cfg.magic || hdr[1] != i_cfg.version) begin
            status = ST_MAGIC;
        end else if (hdr[8] > 8'(MAX_ZONE)) begin
            status = ST_ZONE_LONG;
        end else if (want_len != 9'(len)) begin
            status = ST_LENGTH;
        end else if (secs < i_cfg.floor) begin
            status = ST_EARLY;
        end else if (offs < $signed(i_cfg.ofs_lo) || offs > $signed(i_cfg.ofs_hi)) begin
            status = ST_OFFSET;
        end else begin
            status = ST_OK;
        end
    end

    assign o_push         = accept && i_last;
    assign o_desc.status  = status;
    assign o_desc.secs    = secs;
    assign o_desc.offs    = offs;
    assign o_desc.zlen    = (status == ST_SHORT) ? '0 : hdr[8][COUNT_W-1:0];
    assign o_desc.bank    = r_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bank  <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_count <= '0;
                r_bank  <= !r_bank;
            end else begin
                r_count <= len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (accept && r_count == COUNT_W'(i)) begin
                r_hdr[i] <= i_byte;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tfp_queue.sv @@
// Two-entry frame queue between front and back end; the head stays until
// the back end loads the frame's summary into its output. Uses tfp_pkg.
`default_nettype none

module tfp_queue
    import tfp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_desc      o_head
);

    t_desc             r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_desc;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tfp_back.sv @@
// Back end: plays out a finished frame, zone bytes from the buffer first
// if it passed, then the summary, via a registered output. Uses tfp_pkg.
`default_nettype none

module tfp_back
    import tfp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_empty,
    input  wire t_desc                  i_head,
    output logic                        o_pop,
    output logic                        o_re,
    output logic [ZADDR_W-1:0]          o_raddr,
    input  wire logic [7:0]             i_rdata,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [OUT_TDATA_W-1:0]      o_tdata,
    output logic                        o_tuser,
    output logic                        o_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SUM
    } t_state;

    t_state                   r_state, n_state;
    logic [COUNT_W-1:0]       r_idx, n_idx;
    logic                     r_valid, n_valid;
    logic [OUT_TDATA_W-1:0]   r_tdata, n_tdata;
    logic                     r_tuser, n_tuser;
    logic                     r_tlast, n_tlast;
    logic                     out_free;
    logic                     ok;

    assign out_free = !r_valid || i_ready;
    assign ok       = (i_head.status == ST_OK);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_valid = r_valid && !i_ready;
        n_tdata = r_tdata;
        n_tuser = r_tuser;
        n_tlast = r_tlast;
        o_pop   = 1'b0;
        o_re    = 1'b0;
        o_raddr = zaddr(i_head.bank, r_idx);
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (ok && i_head.zlen != '0) begin
                        o_re    = 1'b1;
                        o_raddr = zaddr(i_head.bank, '0);
                        n_idx   = COUNT_W'(1);
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_FETCH: begin
                // read data holds until it is loaded into the output
                if (out_free) begin
                    n_valid = 1'b1;
                    n_tuser = KIND_ZONE;
                    n_tlast = 1'b0;
                    n_tdata = {{OUT_PAD_W{1'b0}}, {COUNT_W{1'b0}}, 16'd0, 32'd0,
                               ST_OK, i_rdata};
                    if (r_idx < i_head.zlen) begin
                        o_re    = 1'b1;
                        n_idx   = r_idx + COUNT_W'(1);
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_tuser = KIND_SUMMARY;
                    n_tlast = 1'b1;
                    n_tdata = {{OUT_PAD_W{1'b0}}, i_head.zlen,
                               ok ? i_head.offs : 16'd0,
                               ok ? i_head.secs : 32'd0,
                               i_head.status, 8'd0};
                    o_pop   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_valid <= n_valid;
            r_tdata <= n_tdata;
            r_tuser <= n_tuser;
            r_tlast <= n_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_tdata = r_tdata;
    assign o_tuser = r_tuser;
    assign o_tlast = r_tlast;

endmodule

`default_nettype wire

@@ rtl/core/time_frame_parser_top.sv @@
// Top level of the time frame parser: configuration registers, front end, frame queue,
// zone buffer RAM and back end. Depends on tfp_pkg and each tfp_* module but tfp_checker.
//
//  channel   direction  handshake                 payload
//  s (bytes) in         i_s_tvalid / o_s_tready   tdata[7:0] data_byte, tlast end_of_frame
//  m (items) out        o_m_tvalid / i_m_tready   tdata see port, tuser item_kind,
//                                                 tlast run_end
//  cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Bytes are taken one per cycle while fewer than two finished frames wait to
// be played out; the zone buffer has one half per waiting frame.
// The back end emits one result per cycle when i_m_tready is high, except while idle,
// where it takes a frame and, if zone bytes follow, issues the first zone buffer read.
// Reset (synchronous, active low) clears counters, queue and output valid, loads
// the reset configuration; header and zone buffers are not cleared.
// A stalled output only stops the back end; the front keeps taking bytes
// until the queue is full.
`default_nettype none

module time_frame_parser_top
    import tfp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [7:0]             i_s_tdata,   // [7:0] data_byte
    input  wire logic                   i_s_tlast,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // [7:0] zone_char, [10:8] status, [42:11] utc_seconds,
    // [58:43] offset_minutes, [64:59] zone_length, [71:65] zero
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                        o_m_tuser,   // [0] item_kind
    output logic                        o_m_tlast,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [31:0]            i_cfg_data
);

    t_cfg               r_cfg;
    logic               push, pop, q_full, q_empty;
    t_desc              desc, head;
    logic               zone_we, zone_re;
    logic [ZADDR_W-1:0] zone_waddr, zone_raddr;
    logic [7:0]         zone_wdata, zone_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic   <= RST_MAGIC;
            r_cfg.version <= RST_VERSION;
            r_cfg.floor   <= RST_FLOOR;
            r_cfg.ofs_lo  <= RST_OFS_LO;
            r_cfg.ofs_hi  <= RST_OFS_HI;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAGIC:   r_cfg.magic   <= i_cfg_data[7:0];
                CFG_VERSION: r_cfg.version <= i_cfg_data[7:0];
                CFG_FLOOR:   r_cfg.floor   <= i_cfg_data;
                CFG_OFS_LO:  r_cfg.ofs_lo  <= i_cfg_data[15:0];
                CFG_OFS_HI:  r_cfg.ofs_hi  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    tfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_byte       (i_s_tdata),
        .i_last       (i_s_tlast),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_desc       (desc),
        .o_zone_we    (zone_we),
        .o_zone_addr  (zone_waddr),
        .o_zone_wdata (zone_wdata)
    );

    tfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    tfp_ram #(
        .WIDTH (8),
        .DEPTH (ZONE_DEPTH)
    ) u_zone_ram (
        .i_clk   (i_clk),
        .i_we    (zone_we),
        .i_waddr (zone_waddr),
        .i_wdata (zone_wdata),
        .i_re    (zone_re),
        .i_raddr (zone_raddr),
        .o_rdata (zone_rdata)
    );

    tfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_re    (zone_re),
        .o_raddr (zone_raddr),
        .i_rdata (zone_rdata),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_tdata (o_m_tdata),
        .o_tuser (o_m_tuser),
        .o_tlast (o_m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/tfp_checker.sv @@
// Port-level checks of the time frame parser, bound to the top level.
// Depends on tfp_pkg and time_frame_parser_top.
`default_nettype none

module tfp_checker
    import tfp_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tvalid,
    input wire logic                   o_s_tready,
    input wire logic [7:0]             i_s_tdata,
    input wire logic                   i_s_tlast,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                   o_m_tuser,
    input wire logic                   o_m_tlast
);

    // after reset nothing is pending and bytes are welcome
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("output valid or input stalled right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
                                      $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // the summary, and only the summary, closes a run
    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == KIND_SUMMARY) == o_m_tlast)
        else $error("run end does not match item kind");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[10:8] != ST_OK |->
            o_m_tuser == KIND_SUMMARY && o_m_tdata[58:11] == '0 &&
            o_m_tdata[7:0] == '0)
        else $error("failed frame carries decoded fields");

    a_short_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[10:8] == ST_SHORT |-> o_m_tdata[64:59] == '0)
        else $error("short frame reports a zone length");

endmodule

bind time_frame_parser_top tfp_checker u_tfp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking bench for time_frame_parser_top: frames are streamed byte by byte, results
// are predicted per accepted byte and checked in order. Depends on tfp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import tfp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } t_link_byte;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         zchar;
        t_status            status;
        logic [31:0]        secs;
        logic [15:0]        offs;
        logic [COUNT_W-1:0] zlen;
        logic               run_end;
    } t_frame_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata = '0;   // [7:0] data_byte
    logic                   i_s_tlast = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [7:0] zone_char, [10:8] status, [42:11] utc_seconds,
    // [58:43] offset_minutes, [64:59] zone_length, [71:65] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;        // [0] item_kind
    logic                   o_m_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [31:0]            i_cfg_data = '0;

    time_frame_parser_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [7:0]         want_magic   = RST_MAGIC;
    logic [7:0]         want_version = RST_VERSION;
    logic [31:0]        secs_floor   = RST_FLOOR;
    logic signed [15:0] ofs_lo       = RST_OFS_LO;
    logic signed [15:0] ofs_hi       = RST_OFS_HI;

    // predictor frame state
    int         frame_pos = 0;
    logic [7:0] hdr_bytes  [HDR_BYTES];
    logic [7:0] zone_bytes [MAX_ZONE];

    t_link_byte    link_q[$];
    t_frame_result due_results[$];
    int            bytes_queued = 0;
    int            mismatches = 0;
    bit            s_gappy = 1'b0;
    bit            m_gappy = 1'b0;
    bit            long_hold_req = 1'b0;
    int            hold_left = 0;
    int            s_wait = 0;
    int            m_wait = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Advance the frame state by one byte; on the end byte queue what the block must emit.
    function automatic void parse_byte(input logic [7:0] b, input logic eof);
        int                 pos;
        int                 len;
        int                 zl;
        logic [31:0]        secs;
        logic signed [15:0] offs;
        t_status            st;
        t_frame_result      r;
        t_frame_result      z;
        pos = frame_pos;
        if (pos < HDR_BYTES)
            hdr_bytes[pos] = b;
        else if (pos < COUNT_MAX && pos - HDR_BYTES < MAX_ZONE)
            zone_bytes[pos - HDR_BYTES] = b;
        len = (pos < COUNT_MAX) ? pos + 1 : COUNT_MAX;
        if (!eof) begin
            frame_pos = len;
            return;
        end
        frame_pos = 0;
        r = '0;
        r.kind = KIND_SUMMARY;
        r.run_end = 1'b1;
        if (len < HDR_BYTES) begin
            r.status = ST_SHORT;
            due_results.push_back(r);
            return;
        end
        zl   = hdr_bytes[8];
        secs = {hdr_bytes[5], hdr_bytes[4], hdr_bytes[3], hdr_bytes[2]};
        offs = {hdr_bytes[7], hdr_bytes[6]};
        if (hdr_bytes[0] != want_magic || hdr_bytes[1] != want_version)
            st = ST_MAGIC;
        else if (zl > MAX_ZONE)
            st = ST_ZONE_LONG;
        else if (len != HDR_BYTES + zl)
            st = ST_LENGTH;
        else if (secs < secs_floor)
            st = ST_EARLY;
        else if (offs < ofs_lo || offs > ofs_hi)
            st = ST_OFFSET;
        else
            st = ST_OK;
        r.status = st;
        r.zlen = COUNT_W'(zl);
        if (st == ST_OK) begin
            for (int i = 0; i < zl; i++) begin
                z = '0;
                z.kind = KIND_ZONE;
                z.zchar = zone_bytes[i];
                due_results.push_back(z);
            end
            r.secs = secs;
            r.offs = offs;
        end
        due_results.push_back(r);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // byte sender
    always @(posedge i_clk) begin : tx_side
        t_link_byte nb;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                parse_byte(i_s_tdata, i_s_tlast);
            if (!i_s_tvalid || o_s_tready) begin
                if (s_wait > 0) begin
                    s_wait--;
                    i_s_tvalid <= 1'b0;
                end else if (link_q.size() != 0) begin
                    nb = link_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= nb.data;
                    i_s_tlast  <= nb.eof;
                    if (s_gappy)
                        s_wait = pick_gap();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge i_clk) begin : rx_hold
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (long_hold_req) begin
            hold_left <= 400;
            long_hold_req = 1'b0;
        end
    end

    // result receiver and checker
    always @(posedge i_clk) begin : rx_side
        t_frame_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual %0h", $time,
                             o_m_tdata);
                end else begin
                    want = due_results.pop_front();
                    check_field("item_kind", want.kind, o_m_tuser);
                    check_field("zone_char", want.zchar, o_m_tdata[7:0]);
                    check_field("status", want.status, o_m_tdata[10:8]);
                    check_field("utc_seconds", want.secs, o_m_tdata[42:11]);
                    check_field("offset_minutes", want.offs, o_m_tdata[58:43]);
                    check_field("zone_length", want.zlen, o_m_tdata[64:59]);
                    check_field("run_end", want.run_end, o_m_tlast);
                end
            end
            if (hold_left != 0) begin
                i_m_tready <= 1'b0;
            end else if (m_wait > 0) begin
                m_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (m_gappy && $urandom_range(3) == 0)
                    m_wait = pick_gap();
            end
        end
    end

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MAGIC:   want_magic   = val[7:0];
            CFG_VERSION: want_version = val[7:0];
            CFG_FLOOR:   secs_floor   = val;
            CFG_OFS_LO:  ofs_lo       = val[15:0];
            CFG_OFS_HI:  ofs_hi       = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_offsets(input logic [15:0] lo, input logic [15:0] hi);
        write_reg(CFG_OFS_LO, {{16{lo[15]}}, lo});
        write_reg(CFG_OFS_HI, {{16{hi[15]}}, hi});
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eof);
        t_link_byte lb;
        lb.data = b;
        lb.eof  = eof;
        link_q.push_back(lb);
        bytes_queued++;
    endtask

    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom), i == n - 1);
    endtask

    task automatic push_frame(input logic [7:0] mg, input logic [7:0] ver,
                              input logic [31:0] secs, input logic [15:0] offs,
                              input logic [7:0] zdecl, input int zcount);
        logic [7:0] hdr [HDR_BYTES];
        int         total;
        hdr = '{mg, ver, secs[7:0], secs[15:8], secs[23:16], secs[31:24],
                offs[7:0], offs[15:8], zdecl};
        total = HDR_BYTES + zcount;
        for (int i = 0; i < total; i++)
            push_byte(i < HDR_BYTES ? hdr[i] : 8'($urandom), i == total - 1);
    endtask

    // mostly frames that pass every check, the rest broken one way or another
    task automatic push_random_frame();
        int          r;
        int          zc;
        int          offs;
        int          lo;
        int          hi;
        logic [7:0]  zl;
        logic [7:0]  mg;
        logic [7:0]  ver;
        logic [31:0] secs;
        r   = $urandom_range(99);
        lo  = ofs_lo;
        hi  = ofs_hi;
        zl  = ($urandom_range(7) == 0) ? 8'($urandom_range(MAX_ZONE)) : 8'($urandom_range(6));
        zc  = zl;
        mg  = want_magic;
        ver = want_version;
        secs = $urandom_range(32'hFFFF_FFFF, secs_floor);
        if (lo <= hi)
            offs = lo + $urandom_range(hi - lo);
        else
            offs = $urandom;
        if (r < 68) begin
            // well formed
        end else if (r < 72) begin
            mg ^= 8'($urandom_range(255, 1));
        end else if (r < 76) begin
            ver ^= 8'($urandom_range(255, 1));
        end else if (r < 80) begin
            zl = 8'($urandom_range(255, MAX_ZONE + 1));
            zc = $urandom_range(40);
        end else if (r < 85) begin
            if (zl != 0 && $urandom_range(1))
                zc = zl - 1;
            else
                zc = zl + $urandom_range(3, 1);
        end else if (r < 89) begin
            if (secs_floor != 0)
                secs = $urandom_range(secs_floor - 1);
        end else if (r < 93) begin
            if (hi < 32767 && (lo == -32768 || $urandom_range(1)))
                offs = hi + 1 + $urandom_range(32766 - hi);
            else if (lo > -32768)
                offs = lo - 1 - $urandom_range(lo + 32767);
        end else begin
            push_noise(($urandom_range(9) == 0) ? $urandom_range(80, 40) : $urandom_range(20, 1));
            return;
        end
        push_frame(mg, ver, secs, 16'(offs), zl, zc);
    endtask

    task automatic randomize_regs();
        logic [31:0] fl;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] t;
        write_reg(CFG_MAGIC, $urandom_range(255));
        write_reg(CFG_VERSION, $urandom_range(255));
        case ($urandom_range(3))
            0:       fl = '0;
            1:       fl = $urandom;
            2:       fl = 32'hFFFF_FFFF;
            default: fl = $urandom_range(1 << 20);
        endcase
        write_reg(CFG_FLOOR, fl);
        a = $urandom;
        b = $urandom;
        // an empty window now and then
        if ($urandom_range(9) != 0 && $signed(a) > $signed(b)) begin
            t = a;
            a = b;
            b = t;
        end
        write_offsets(a, b);
    endtask

    // wait until all queued bytes are sent and all results are out, then let the pipe settle
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (link_q.size() != 0 || i_s_tvalid || due_results.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int base;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values
        s_gappy = 1'b1;
        m_gappy = 1'b1;
        push_byte(8'hFF, 1'b1);
        push_noise(HDR_BYTES - 1);
        push_frame(8'h00, 8'h01, 32'h0, 16'hFD30, 8'd0, 0);            // offset at low bound
        push_frame(8'h00, 8'h01, 32'hFFFF_FFFF, 16'd840, 8'd32, 32);    // longest zone
        push_frame(8'h00, 8'h01, 32'd1234, 16'd841, 8'd1, 1);
        push_frame(8'h00, 8'h01, 32'd1234, 16'hFD2F, 8'd2, 2);
        push_frame(8'h5A, 8'h01, 32'd5, 16'd0, 8'd1, 1);
        push_frame(8'h00, 8'hFF, 32'd5, 16'd0, 8'd1, 1);
        push_frame(8'h00, 8'h01, 32'd5, 16'd0, 8'd33, 33);
        push_frame(8'h00, 8'h01, 32'd5, 16'd0, 8'd255, 0);
        push_frame(8'h00, 8'h01, 32'd5, 16'd0, 8'd5, 4);
        push_frame(8'h00, 8'h01, 32'd5, 16'd0, 8'd5, 6);
        push_frame(8'h00, 8'h01, 32'd5, 16'd0, 8'd0, 3);
        // counter saturation: frames of 63 bytes and more
        push_frame(8'h00, 8'h01, 32'd5, 16'd0, 8'd54, 54);
        push_frame(8'h00, 8'h01, 32'd5, 16'd0, 8'd32, 60);
        wait_drained();

        // extreme registers
        write_reg(CFG_MAGIC, 32'hFF);
        write_reg(CFG_VERSION, 32'h00);
        write_reg(CFG_FLOOR, 32'hFFFF_FFFF);
        write_offsets(16'h8000, 16'h7FFF);
        push_frame(8'hFF, 8'h00, 32'hFFFF_FFFF, 16'h8000, 8'd3, 3);
        push_frame(8'hFF, 8'h00, 32'hFFFF_FFFF, 16'h7FFF, 8'd0, 0);
        push_frame(8'hFF, 8'h00, 32'hFFFF_FFFE, 16'h0, 8'd0, 0);
        wait_drained();

        // narrow window, then check precedence with several faults at once
        write_reg(CFG_MAGIC, 32'hA5);
        write_reg(CFG_VERSION, 32'h5A);
        write_reg(CFG_FLOOR, 32'd1000);
        write_offsets(16'h0, 16'h0);
        push_frame(8'hA5, 8'h5A, 32'd999, 16'h0, 8'd1, 1);
        push_frame(8'hA5, 8'h5A, 32'd1000, 16'h0, 8'd2, 2);
        push_frame(8'hA5, 8'h5A, 32'd1000, 16'h1, 8'd0, 0);
        push_frame(8'hA5, 8'h5A, 32'd1000, 16'hFFFF, 8'd0, 0);
        push_frame(8'h00, 8'h5A, 32'd0, 16'h9, 8'd40, 2);
        push_frame(8'hA5, 8'h5A, 32'd0, 16'h9, 8'd40, 2);
        push_frame(8'hA5, 8'h5A, 32'd0, 16'h9, 8'd4, 2);
        push_frame(8'hA5, 8'h5A, 32'd0, 16'h9, 8'd4, 4);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            randomize_regs();
            s_gappy = (ph != 2) && (ph == 0 || $urandom_range(1));
            m_gappy = (ph != 2) && (ph == 0 || $urandom_range(1));
            if (ph == 3) begin
                // output blocked for a while: the frame queue fills and input backs up
                long_hold_req = 1'b1;
                for (int k = 0; k < 5; k++)
                    push_frame(want_magic, want_version, $urandom_range(32'hFFFF_FFFF,
                               secs_floor), ofs_lo, 8'($urandom_range(2)), 0);
            end
            base = bytes_queued;
            while (bytes_queued - base < 10)
                push_random_frame();
            wait_drained();
        end

        if (mismatches == 0 && due_results.size() == 0)
            $display("time_frame_parser_top test passed");
        else
            $display("time_frame_parser_top test failed");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("time_frame_parser_top test failed");
        $finish;
    end

endmodule
